// ----- hdl/upscl_pkg.sv -----
// Shared types and constants for the integer pixel replication upscaler.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package upscl_pkg;

  localparam int PIX_BITS      = 24;
  localparam int LW_BITS       = 13;
  localparam int SCALE_BITS    = 4;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 13;

  // Command queue between the front and the back.
  localparam int QDEPTH   = 4;
  localparam int QPTR     = $clog2(QDEPTH);
  localparam int QLVL     = $clog2(QDEPTH + 1);

  localparam logic [LW_BITS-1:0]    LINE_WIDTH_RST = 13'd640;
  localparam logic [SCALE_BITS-1:0] SCALE_RST      = 4'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE      = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_IDLE_TICK = 2'd2
  } status_e;

  typedef struct packed {
    logic                kind;
    logic [PIX_BITS-1:0] pixel_value;
  } in_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] out_pixel;
    logic                run_last;
    logic                row_end;
    status_e             status;
  } out_t;

  // One classified item: a pixel to be repeated count times.
  typedef struct packed {
    logic [PIX_BITS-1:0]   pixel;
    logic [SCALE_BITS-1:0] count;
    logic                  at_end;
    status_e               status;
  } entry_t;

endpackage

`default_nettype wire

// ----- hdl/integer_pixel_replication_upscaler.sv -----
// Integer pixel replication upscaler. Each source pixel comes out scale_factor
// times, back to back while the output is not stalled, and after the last pixel
// of a line each replay tick re-emits the next stored pixel scale_factor times,
// scale_factor-1 passes per line. A dropped pixel or an idle tick yields a single
// result; the output register sets the rate, one result per cycle while
// out_stall_i is low, and input items are taken back to back while a four-entry
// command queue has room. An accepted item passes through the classify and store
// read stage, then the queue, then the output register before its result is
// offered. Configuration registers: index 0 line_width, index 1 scale_factor;
// write them only while the block is idle. The line store is sized by MAX_WIDTH
// and needs no initialization.
`default_nettype none

module integer_pixel_replication_upscaler #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SCALE = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  upscl_pkg::in_t                       in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output upscl_pkg::out_t                      out_data_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [upscl_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire  [upscl_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  logic                           push;
  upscl_pkg::entry_t              push_entry;
  logic                           pop;
  logic                           head_valid;
  upscl_pkg::entry_t              head;
  logic [upscl_pkg::QLVL-1:0]     level;

  assign cfg_ready_o = 1'b1;

  upscl_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fifo_level_i (level),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  upscl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .level_o      (level)
  );

  upscl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ----- hdl/upscl_front.sv -----
// Front part of the upscaler: configuration registers, line store, column and
// replay bookkeeping. Classifies each item into a queue entry. Uses upscl_pkg.
`default_nettype none

module upscl_front #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SCALE = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  upscl_pkg::in_t                       in_data_i,
  input  wire                                  cfg_valid_i,
  input  wire  [upscl_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire  [upscl_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire  [upscl_pkg::QLVL-1:0]           fifo_level_i,
  output logic                                 push_o,
  output upscl_pkg::entry_t                    push_entry_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = $clog2(MAX_SCALE);

  logic [upscl_pkg::LW_BITS-1:0]    line_width_q;
  logic [upscl_pkg::SCALE_BITS-1:0] scale_q;

  logic [CW-1:0] source_col_q, source_col_d;
  logic [CW-1:0] replay_col_q, replay_col_d;
  logic [PW-1:0] passes_q, passes_d;
  logic          replaying_q, replaying_d;

  logic                    s1_valid_q;
  logic                    s1_use_mem_q, s1_use_mem_d;
  upscl_pkg::entry_t       s1_entry_q, s1_entry_d;

  logic [upscl_pkg::PIX_BITS-1:0] line_mem [MAX_WIDTH];
  logic [upscl_pkg::PIX_BITS-1:0] rdata_q;

  logic [CW-1:0]                    last_col;
  logic [upscl_pkg::SCALE_BITS-1:0] eff_scale;
  logic [CW-1:0]                    src_col;
  logic [CW-1:0]                    rep_col;
  logic                             src_end;
  logic                             rep_end;
  logic [PW-1:0]                    passes_dec;
  logic                             accept;
  logic                             mem_we;
  logic                             mem_re;

  // Effective width and scale, clamped to what the storage supports.
  always_comb begin
    if (line_width_q == '0) begin
      last_col = '0;
    end else if (int'(line_width_q) > MAX_WIDTH) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(line_width_q - upscl_pkg::LW_BITS'(1));
    end
    if (scale_q == '0) begin
      eff_scale = upscl_pkg::SCALE_BITS'(1);
    end else if (int'(scale_q) > MAX_SCALE) begin
      eff_scale = upscl_pkg::SCALE_BITS'(MAX_SCALE);
    end else begin
      eff_scale = scale_q;
    end
  end

  // Hold off a new item when the queue might not have room for it and the
  // one still in the read stage.
  assign in_stall_o = (fifo_level_i + upscl_pkg::QLVL'(s1_valid_q))
                      >= upscl_pkg::QLVL'(upscl_pkg::QDEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  assign src_col    = (source_col_q > last_col) ? last_col : source_col_q;
  assign rep_col    = (replay_col_q > last_col) ? last_col : replay_col_q;
  assign src_end    = (src_col == last_col);
  assign rep_end    = (rep_col == last_col);
  assign passes_dec = (passes_q != '0) ? passes_q - PW'(1) : passes_q;

  always_comb begin
    source_col_d = source_col_q;
    replay_col_d = replay_col_q;
    passes_d     = passes_q;
    replaying_d  = replaying_q;
    s1_use_mem_d = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    s1_entry_d.pixel  = '0;
    s1_entry_d.count  = upscl_pkg::SCALE_BITS'(1);
    s1_entry_d.at_end = 1'b0;
    s1_entry_d.status = upscl_pkg::ST_OK;
    if (in_data_i.kind == upscl_pkg::KIND_PIXEL) begin
      if (replaying_q) begin
        s1_entry_d.status = upscl_pkg::ST_DROPPED;
      end else begin
        mem_we            = accept;
        s1_entry_d.pixel  = in_data_i.pixel_value;
        s1_entry_d.count  = eff_scale;
        s1_entry_d.at_end = src_end;
        if (src_end) begin
          source_col_d = '0;
          if (eff_scale > upscl_pkg::SCALE_BITS'(1)) begin
            replaying_d  = 1'b1;
            passes_d     = PW'(eff_scale - upscl_pkg::SCALE_BITS'(1));
            replay_col_d = '0;
          end
        end else begin
          source_col_d = src_col + CW'(1);
        end
      end
    end else begin
      if (!replaying_q) begin
        s1_entry_d.status = upscl_pkg::ST_IDLE_TICK;
      end else begin
        mem_re            = accept;
        s1_use_mem_d      = 1'b1;
        s1_entry_d.count  = eff_scale;
        s1_entry_d.at_end = rep_end;
        if (rep_end) begin
          replay_col_d = '0;
          passes_d     = passes_dec;
          if (passes_dec == '0) begin
            replaying_d = 1'b0;
          end
        end else begin
          replay_col_d = rep_col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= upscl_pkg::LINE_WIDTH_RST;
      scale_q      <= upscl_pkg::SCALE_RST;
      source_col_q <= '0;
      replay_col_q <= '0;
      passes_q     <= '0;
      replaying_q  <= 1'b0;
      s1_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          upscl_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data_i;
          upscl_pkg::REG_SCALE:      scale_q <= cfg_data_i[upscl_pkg::SCALE_BITS-1:0];
          default:                   line_width_q <= line_width_q;
        endcase
      end
      s1_valid_q <= accept;
      if (accept) begin
        source_col_q <= source_col_d;
        replay_col_q <= replay_col_d;
        passes_q     <= passes_d;
        replaying_q  <= replaying_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_entry_q   <= s1_entry_d;
      s1_use_mem_q <= s1_use_mem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[src_col] <= in_data_i.pixel_value;
    end
    if (mem_re) begin
      rdata_q <= line_mem[rep_col];
    end
  end

  always_comb begin
    push_entry_o = s1_entry_q;
    if (s1_use_mem_q) begin
      push_entry_o.pixel = rdata_q;
    end
  end

  assign push_o = s1_valid_q;

endmodule

`default_nettype wire

// ----- hdl/upscl_fifo.sv -----
// Short command queue between the front and the back of the upscaler.
// Holds classified entries; uses types and depth from upscl_pkg.
`default_nettype none

module upscl_fifo (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          push_i,
  input  upscl_pkg::entry_t            push_entry_i,
  input  wire                          pop_i,
  output logic                         head_valid_o,
  output upscl_pkg::entry_t            head_o,
  output logic [upscl_pkg::QLVL-1:0]   level_o
);

  upscl_pkg::entry_t               slots_q [upscl_pkg::QDEPTH];
  logic [upscl_pkg::QPTR-1:0]      wptr_q;
  logic [upscl_pkg::QPTR-1:0]      rptr_q;
  logic [upscl_pkg::QLVL-1:0]      level_q;
  logic                            do_pop;

  // The front never pushes into a full queue.
  assign do_pop       = pop_i && (level_q != '0);
  assign head_valid_o = (level_q != '0);
  assign head_o       = slots_q[rptr_q];
  assign level_o      = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + upscl_pkg::QPTR'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + upscl_pkg::QPTR'(1);
      end
      if (push_i && !do_pop) begin
        level_q <= level_q + upscl_pkg::QLVL'(1);
      end else if (!push_i && do_pop) begin
        level_q <= level_q - upscl_pkg::QLVL'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/upscl_back.sv -----
// Back part of the upscaler: repeats the head queue entry into output pixels,
// one per cycle while out_stall_i allows, into a registered output. Uses upscl_pkg.
`default_nettype none

module upscl_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 head_valid_i,
  input  upscl_pkg::entry_t   head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output upscl_pkg::out_t     out_data_o
);

  logic [upscl_pkg::SCALE_BITS-1:0] copy_q;
  logic                             out_valid_q;
  upscl_pkg::out_t                  out_q;
  logic                             adv;
  logic                             emit;
  logic                             last;

  // The output register may load when empty or when its transfer completes.
  assign adv  = !out_valid_q || !out_stall_i;
  assign emit = adv && head_valid_i;
  assign last = ({1'b0, copy_q} + (upscl_pkg::SCALE_BITS + 1)'(1))
                == {1'b0, head_i.count};
  assign pop_o = emit && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= emit;
      end
      if (pop_o) begin
        copy_q <= '0;
      end else if (emit) begin
        copy_q <= copy_q + upscl_pkg::SCALE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_pixel <= head_i.pixel;
      out_q.run_last  <= last;
      out_q.row_end   <= last && head_i.at_end;
      out_q.status    <= head_i.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
